// ----- sv/imuoc_pkg.sv -----
// Shared types and constants for the IMU offset calibrate/compensate block.
// Used by imuoc_div and imu_offset_calibrate_compensate; no dependencies.
package imuoc_pkg;

  localparam int unsigned Axes       = 6;
  localparam int unsigned AxisW      = 16;
  localparam int unsigned SumW       = 33;
  localparam int unsigned OffW       = 17;
  localparam int unsigned CountW     = 16;
  localparam int unsigned GravW      = 15;
  localparam int unsigned DivdW      = 32;
  localparam int unsigned DivsW      = 16;
  localparam int unsigned AxisIdxW   = 3;
  localparam int unsigned AccZAxis   = 2;

  localparam logic [AxisIdxW-1:0] LastAxis = AxisIdxW'(Axes - 1);

  localparam logic [CountW-1:0] CalCountReset = 16'd800;
  localparam logic [GravW-1:0]  GravityReset  = 15'd4096;

  // register indexes
  localparam logic RegCalCount = 1'b0;
  localparam logic RegGravity  = 1'b1;

  // item kinds
  localparam logic CmdCompensate = 1'b0;
  localparam logic CmdCalibrate  = 1'b1;

  // result status codes
  localparam logic [2:0] StOk          = 3'd0;
  localparam logic [2:0] StReadFail    = 3'd1;
  localparam logic [2:0] StCalibrating = 3'd2;
  localparam logic [2:0] StCalDone     = 3'd3;
  localparam logic [2:0] StCalFail     = 3'd4;

  localparam logic signed [AxisW-1:0] Int16Max = 16'sh7fff;
  localparam logic signed [AxisW-1:0] Int16Min = 16'sh8000;

  typedef logic signed [SumW-1:0] sum_t;
  typedef logic signed [OffW-1:0] off_t;

endpackage

// ----- sv/imuoc_div.sv -----
// Shared restoring divider, one quotient bit per cycle, unsigned operands.
// Depends on imuoc_pkg for operand widths.
module imuoc_div (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  input  logic [imuoc_pkg::DivdW-1:0]     dividend_i,
  input  logic [imuoc_pkg::DivsW-1:0]     divisor_i,
  output logic [imuoc_pkg::DivdW-1:0]     quotient_o,
  output logic                            done_o
);

  localparam int unsigned CntW = $clog2(imuoc_pkg::DivdW);

  logic                          busy_q, busy_d;
  logic [CntW-1:0]               cnt_q, cnt_d;
  logic [imuoc_pkg::DivsW-1:0]   rem_q, rem_d;
  logic [imuoc_pkg::DivdW-1:0]   quo_q, quo_d;
  logic [imuoc_pkg::DivsW-1:0]   dvs_q, dvs_d;
  logic [imuoc_pkg::DivsW:0]     trial;
  logic [imuoc_pkg::DivsW:0]     diff;
  logic                          fits;

  always_comb begin
    trial = {rem_q, quo_q[imuoc_pkg::DivdW-1]};
    diff  = trial - {1'b0, dvs_q};
    fits  = trial >= {1'b0, dvs_q};
    busy_d = busy_q;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CntW'(imuoc_pkg::DivdW - 1);
      rem_d  = '0;
      quo_d  = dividend_i;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      rem_d = fits ? diff[imuoc_pkg::DivsW-1:0] : trial[imuoc_pkg::DivsW-1:0];
      quo_d = {quo_q[imuoc_pkg::DivdW-2:0], fits};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      rem_q  <= '0;
      quo_q  <= '0;
      dvs_q  <= '0;
      done_o <= 1'b0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
      rem_q  <= rem_d;
      quo_q  <= quo_d;
      dvs_q  <= dvs_d;
      done_o <= busy_q && !start_i && (cnt_q == '0);
    end
  end

  assign quotient_o = quo_q;

endmodule

// ----- sv/imu_offset_calibrate_compensate.sv -----
// IMU offset calibration and compensation, top level.
// Compensate and non-divide calibration words: result registered, valid in the
// cycle after accept; one word per cycle unless the receiver stalls. A run's final
// word with a valid sample: six passes of the shared 32-step divider, no input accepted.
// Reset clears offsets, sums and run state; registers return to 800 and 4096.
// Depends on imuoc_pkg and imuoc_div.
module imu_offset_calibrate_compensate (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic         cfg_addr_i,
  input  logic [15:0]  cfg_data_i,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // in_acc_x, in_acc_y, in_acc_z, in_gyro_x, in_gyro_y, in_gyro_z
  input  logic [95:0]  s_axis_tdata,
  // command, sample_ok
  input  logic [1:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // out_acc_x, out_acc_y, out_acc_z, out_gyro_x, out_gyro_y, out_gyro_z
  output logic [95:0]  m_axis_tdata,
  // status
  output logic [2:0]   m_axis_tuser
);

  typedef enum logic [1:0] {
    StIdle,
    StDivGo,
    StDivWait
  } state_e;

  localparam int unsigned Ax  = imuoc_pkg::Axes;
  localparam int unsigned AW  = imuoc_pkg::AxisW;
  localparam int unsigned DvW = imuoc_pkg::DivdW;

  state_e                                state_q;
  logic [imuoc_pkg::AxisIdxW-1:0]        axis_q;
  logic [imuoc_pkg::CountW-1:0]          cal_cnt_q;
  logic [imuoc_pkg::GravW-1:0]           grav_q;
  logic [imuoc_pkg::CountW-1:0]          left_q, left_d;
  logic [imuoc_pkg::CountW-1:0]          vc_q, vc_d;
  imuoc_pkg::sum_t                       sums_q [Ax];
  imuoc_pkg::sum_t                       sums_d [Ax];
  imuoc_pkg::off_t                       offs_q [Ax];
  logic                                  out_valid_q;
  logic [Ax*AW-1:0]                      out_data_q;
  logic [2:0]                            out_status_q;

  logic                                  accept;
  logic                                  cmd;
  logic                                  ok;
  logic                                  run_start;
  logic                                  refuse;
  logic [Ax*AW-1:0]                      comp_data;
  logic signed [AW+1:0]                  diff [Ax];
  logic signed [AW-1:0]                  raw [Ax];

  logic                                  div_start;
  logic                                  div_done;
  logic [DvW-1:0]                        div_q;
  logic [DvW-1:0]                        div_a;
  imuoc_pkg::sum_t                       sel_sum;
  imuoc_pkg::sum_t                       neg_sum;
  imuoc_pkg::off_t                       quo_s;
  imuoc_pkg::off_t                       off_new;

  assign cmd    = s_axis_tuser[0];
  assign ok     = s_axis_tuser[1];
  assign s_axis_tready = (state_q == StIdle) && (!out_valid_q || m_axis_tready);
  assign accept = s_axis_tvalid && s_axis_tready;

  assign run_start = (left_q == '0);
  assign refuse    = run_start && (cal_cnt_q == '0);

  always_comb begin
    comp_data = '0;
    for (int a = 0; a < Ax; a++) begin
      raw[a]  = s_axis_tdata[a*AW +: AW];
      diff[a] = {{2{raw[a][AW-1]}}, raw[a]} - {offs_q[a][imuoc_pkg::OffW-1], offs_q[a]};
      if (diff[a] > (AW+2)'(imuoc_pkg::Int16Max)) begin
        comp_data[a*AW +: AW] = imuoc_pkg::Int16Max;
      end else if (diff[a] < (AW+2)'(imuoc_pkg::Int16Min)) begin
        comp_data[a*AW +: AW] = imuoc_pkg::Int16Min;
      end else begin
        comp_data[a*AW +: AW] = diff[a][AW-1:0];
      end
      sums_d[a] = (run_start ? '0 : sums_q[a])
                + (ok ? imuoc_pkg::SumW'(raw[a]) : '0);
    end
    vc_d   = (run_start ? '0 : vc_q) + {{(imuoc_pkg::CountW-1){1'b0}}, ok};
    left_d = (run_start ? cal_cnt_q : left_q) - 1'b1;
  end

  // divider operands: magnitude of the selected sum; sign restored on the quotient
  always_comb begin
    sel_sum = sums_q[axis_q];
    neg_sum = -sel_sum;
    div_a   = sel_sum[imuoc_pkg::SumW-1] ? neg_sum[DvW-1:0] : sel_sum[DvW-1:0];
    quo_s   = sel_sum[imuoc_pkg::SumW-1] ? -div_q[imuoc_pkg::OffW-1:0]
                                          : div_q[imuoc_pkg::OffW-1:0];
    off_new = (axis_q == imuoc_pkg::AxisIdxW'(imuoc_pkg::AccZAxis))
            ? quo_s - {2'b00, grav_q} : quo_s;
  end

  assign div_start = (state_q == StDivGo);

  imuoc_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_a),
    .divisor_i  (vc_q),
    .quotient_o (div_q),
    .done_o     (div_done)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= StIdle;
      axis_q       <= '0;
      cal_cnt_q    <= imuoc_pkg::CalCountReset;
      grav_q       <= imuoc_pkg::GravityReset;
      left_q       <= '0;
      vc_q         <= '0;
      out_valid_q  <= 1'b0;
      out_data_q   <= '0;
      out_status_q <= imuoc_pkg::StOk;
      for (int a = 0; a < Ax; a++) begin
        sums_q[a] <= '0;
        offs_q[a] <= '0;
      end
    end else begin
      if (cfg_we_i) begin
        case (cfg_addr_i)
          imuoc_pkg::RegCalCount: cal_cnt_q <= cfg_data_i;
          imuoc_pkg::RegGravity:  grav_q    <= cfg_data_i[imuoc_pkg::GravW-1:0];
          default: ;
        endcase
      end

      if (out_valid_q && m_axis_tready && !accept) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        StIdle: begin
          if (accept) begin
            if (cmd == imuoc_pkg::CmdCompensate) begin
              out_valid_q  <= 1'b1;
              out_data_q   <= ok ? comp_data : '0;
              out_status_q <= ok ? imuoc_pkg::StOk : imuoc_pkg::StReadFail;
            end else if (refuse) begin
              out_valid_q  <= 1'b1;
              out_data_q   <= '0;
              out_status_q <= imuoc_pkg::StCalFail;
            end else begin
              if (run_start) begin
                for (int a = 0; a < Ax; a++) begin
                  offs_q[a] <= '0;
                end
              end
              for (int a = 0; a < Ax; a++) begin
                sums_q[a] <= sums_d[a];
              end
              vc_q   <= vc_d;
              left_q <= left_d;
              if (left_d != '0) begin
                out_valid_q  <= 1'b1;
                out_data_q   <= '0;
                out_status_q <= imuoc_pkg::StCalibrating;
              end else if (vc_d == '0) begin
                out_valid_q  <= 1'b1;
                out_data_q   <= '0;
                out_status_q <= imuoc_pkg::StCalFail;
              end else begin
                // any pending result word is taken at this edge
                out_valid_q <= 1'b0;
                axis_q      <= '0;
                state_q     <= StDivGo;
              end
            end
          end
        end
        StDivGo: begin
          state_q <= StDivWait;
        end
        StDivWait: begin
          if (div_done) begin
            offs_q[axis_q] <= off_new;
            if (axis_q == imuoc_pkg::LastAxis) begin
              out_valid_q  <= 1'b1;
              out_data_q   <= '0;
              out_status_q <= imuoc_pkg::StCalDone;
              state_q      <= StIdle;
            end else begin
              axis_q  <= axis_q + 1'b1;
              state_q <= StDivGo;
            end
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_status_q;

endmodule

// ----- tb/tb_imu_offset_calibrate_compensate.sv -----
// Self-checking testbench for imu_offset_calibrate_compensate: directed corner cases and
// paced random traffic, checked word by word against a built-in calibration predictor.
// Depends on imuoc_pkg and the block's RTL.
`timescale 1ns / 1ps

module tb_imu_offset_calibrate_compensate;

  localparam int unsigned CycleLimit = 2_000_000;
  localparam int unsigned DrainCycles = 256;  // longer than one six-pass divide
  localparam int unsigned Axes = imuoc_pkg::Axes;
  localparam int unsigned AxisW = imuoc_pkg::AxisW;

  typedef logic [Axes-1:0][AxisW-1:0] imu_axes_t;

  typedef struct packed {
    logic      cmd;
    logic      ok;
    imu_axes_t raw;
  } imu_sample_t;

  typedef struct packed {
    imu_axes_t  axes;
    logic [2:0] status;
  } imu_result_t;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic        cfg_addr_i;
  logic [15:0] cfg_data_i;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  // in_acc_x, in_acc_y, in_acc_z, in_gyro_x, in_gyro_y, in_gyro_z
  logic [95:0] s_axis_tdata;
  logic [1:0]  s_axis_tuser;   // command, sample_ok
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  // out_acc_x, out_acc_y, out_acc_z, out_gyro_x, out_gyro_y, out_gyro_z
  logic [95:0] m_axis_tdata;
  logic [2:0]  m_axis_tuser;   // status

  imu_offset_calibrate_compensate dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  // predictor state and register copies
  logic [imuoc_pkg::CountW-1:0] cal_count_q;
  logic [imuoc_pkg::GravW-1:0]  gravity_q;
  int unsigned       left_cnt;
  int unsigned       valid_cnt;
  longint            axis_sum [Axes];
  int                axis_off [Axes];

  imu_result_t imu_results_due[$];

  int          src_idle_pct;
  int          sink_stall_pct;
  int          errors;
  int unsigned words_sent;
  int unsigned words_checked;
  int unsigned runs_done;
  int unsigned runs_failed;
  int unsigned cycle_cnt;

  string axis_field [Axes] = '{"out_acc_x", "out_acc_y", "out_acc_z",
                               "out_gyro_x", "out_gyro_y", "out_gyro_z"};

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CycleLimit) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_cnt,
               imu_results_due.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  // receiver back-pressure
  always @(negedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
  end

  always @(posedge clk_i) begin : check_results
    imu_result_t got;
    imu_result_t want;
    int i;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.axes   = m_axis_tdata;
      got.status = m_axis_tuser;
      words_checked++;
      if (imu_results_due.size() == 0) begin
        $error("result word with nothing outstanding: status %0d", got.status);
        errors++;
      end else begin
        want = imu_results_due.pop_front();
        for (i = 0; i < Axes; i++) begin
          if (got.axes[i] !== want.axes[i]) begin
            $error("%s: expected %0d, actual %0d", axis_field[i],
                   $signed(want.axes[i]), $signed(got.axes[i]));
            errors++;
          end
        end
        if (got.status !== want.status) begin
          $error("status: expected %0d, actual %0d", want.status, got.status);
          errors++;
        end
      end
    end
  end

  function automatic logic [AxisW-1:0] sat_axis(input int v);
    if (v > int'(imuoc_pkg::Int16Max)) return imuoc_pkg::Int16Max;
    if (v < int'(imuoc_pkg::Int16Min)) return imuoc_pkg::Int16Min;
    return v[AxisW-1:0];
  endfunction

  // Offset averaging and compensation for one accepted word.
  task automatic calibrate_or_compensate(input imu_sample_t s);
    imu_result_t             r;
    logic signed [AxisW-1:0] raw_v;
    int                      i;
    r = '0;
    if (s.cmd == imuoc_pkg::CmdCompensate) begin
      if (!s.ok) begin
        r.status = imuoc_pkg::StReadFail;
      end else begin
        for (i = 0; i < Axes; i++) begin
          raw_v     = s.raw[i];
          r.axes[i] = sat_axis(raw_v - axis_off[i]);
        end
        r.status = imuoc_pkg::StOk;
      end
    end else if (left_cnt == 0 && cal_count_q == 0) begin
      // refused at once, offsets kept
      r.status = imuoc_pkg::StCalFail;
      runs_failed++;
    end else begin
      if (left_cnt == 0) begin
        for (i = 0; i < Axes; i++) begin
          axis_sum[i] = 0;
          axis_off[i] = 0;
        end
        valid_cnt = 0;
        left_cnt  = cal_count_q;
      end
      if (s.ok) begin
        for (i = 0; i < Axes; i++) begin
          raw_v       = s.raw[i];
          axis_sum[i] += raw_v;
        end
        valid_cnt = (valid_cnt + 1) & 16'hffff;
      end
      left_cnt--;
      if (left_cnt != 0) begin
        r.status = imuoc_pkg::StCalibrating;
      end else if (valid_cnt == 0) begin
        r.status = imuoc_pkg::StCalFail;
        runs_failed++;
      end else begin
        // signed divide truncates toward zero
        for (i = 0; i < Axes; i++) axis_off[i] = int'(axis_sum[i] / longint'(valid_cnt));
        axis_off[imuoc_pkg::AccZAxis] -= int'(gravity_q);
        r.status = imuoc_pkg::StCalDone;
        runs_done++;
      end
    end
    imu_results_due.push_back(r);
  endtask

  // Called at a falling edge; returns at the falling edge after the word is taken.
  task automatic send_word(input logic cmd, input logic ok, input imu_axes_t raw);
    imu_sample_t s;
    s.cmd = cmd;
    s.ok  = ok;
    s.raw = raw;
    if (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk_i);
      while ($urandom_range(99) < src_idle_pct) @(negedge clk_i);
    end
    s_axis_tdata  = raw;
    s_axis_tuser  = {ok, cmd};
    s_axis_tvalid = 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    calibrate_or_compensate(s);
    words_sent++;
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    s_axis_tvalid = 1'b0;
    while (imu_results_due.size() != 0) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic cfg_write(input logic addr, input logic [15:0] data);
    cfg_we_i   = 1'b1;
    cfg_addr_i = addr;
    cfg_data_i = data;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    if (addr == imuoc_pkg::RegCalCount) cal_count_q = data;
    else gravity_q = data[imuoc_pkg::GravW-1:0];
  endtask

  function automatic imu_axes_t all_axes(input logic [AxisW-1:0] v);
    imu_axes_t a;
    int i;
    for (i = 0; i < Axes; i++) a[i] = v;
    return a;
  endfunction

  function automatic imu_axes_t pick_sample();
    imu_axes_t a;
    int i;
    for (i = 0; i < Axes; i++) begin
      case ($urandom_range(15))
        0:       a[i] = 16'h7fff;
        1:       a[i] = 16'h8000;
        2:       a[i] = 16'h0000;
        3:       a[i] = 16'hffff;
        default: a[i] = 16'($urandom_range(65535));
      endcase
    end
    return a;
  endfunction

  task automatic randomize_registers();
    int pick;
    logic [15:0] count;
    logic [15:0] grav;
    pick = int'($urandom_range(99));
    if (pick < 5) count = 16'd0;
    else if (pick < 65) count = 16'($urandom_range(1, 4));
    else if (pick < 95) count = 16'($urandom_range(5, 20));
    else count = 16'($urandom_range(21, 64));
    pick = int'($urandom_range(99));
    if (pick < 10) grav = 16'd0;
    else if (pick < 20) grav = 16'h7fff;
    else grav = 16'($urandom_range(32767));
    cfg_write(imuoc_pkg::RegCalCount, count);
    cfg_write(imuoc_pkg::RegGravity, grav);
  endtask

  // ---------------------------------------------------------------- tests

  task automatic test_compensate_at_reset();
    // zero offsets: raw values come straight through
    send_word(imuoc_pkg::CmdCompensate, 1'b1,
              {16'h3039, 16'h0001, 16'hffff, 16'h0000, 16'h8000, 16'h7fff});
    send_word(imuoc_pkg::CmdCompensate, 1'b1, all_axes(16'h8000));
    send_word(imuoc_pkg::CmdCompensate, 1'b0, all_axes(16'h5a5a));
  endtask

  // Run at the reset count and gravity, with a count write in the middle of it.
  task automatic test_default_run();
    send_word(imuoc_pkg::CmdCalibrate, 1'b1, all_axes(16'h7fff));
    send_word(imuoc_pkg::CmdCalibrate, 1'b1, all_axes(16'h8000));
    send_word(imuoc_pkg::CmdCalibrate, 1'b0, all_axes(16'h1234));
    send_word(imuoc_pkg::CmdCompensate, 1'b1, all_axes(16'h4000));
    wait_drained();
    cfg_write(imuoc_pkg::RegCalCount, 16'd2);  // applies from the next run only
    while (left_cnt != 0) begin
      send_word(imuoc_pkg::CmdCalibrate, $urandom_range(19) != 0, pick_sample());
    end
    send_word(imuoc_pkg::CmdCompensate, 1'b1, pick_sample());
  endtask

  task automatic test_saturation();
    wait_drained();
    cfg_write(imuoc_pkg::RegGravity, 16'd0);
    send_word(imuoc_pkg::CmdCalibrate, 1'b1, all_axes(16'h8000));
    send_word(imuoc_pkg::CmdCalibrate, 1'b1, all_axes(16'h8000));
    send_word(imuoc_pkg::CmdCompensate, 1'b1, all_axes(16'h7fff));
    send_word(imuoc_pkg::CmdCompensate, 1'b1, all_axes(16'h8000));
    // gravity is picked up when the run ends, not when it starts
    send_word(imuoc_pkg::CmdCalibrate, 1'b1, all_axes(16'h7fff));
    wait_drained();
    cfg_write(imuoc_pkg::RegGravity, 16'h7fff);
    send_word(imuoc_pkg::CmdCalibrate, 1'b1, all_axes(16'h7fff));
    send_word(imuoc_pkg::CmdCompensate, 1'b1, all_axes(16'h8000));
  endtask

  task automatic test_no_valid_sample();
    send_word(imuoc_pkg::CmdCalibrate, 1'b0, all_axes(16'h7fff));
    send_word(imuoc_pkg::CmdCalibrate, 1'b0, all_axes(16'h8000));
    send_word(imuoc_pkg::CmdCompensate, 1'b1, all_axes(16'h0123));
  endtask

  task automatic test_truncation();
    // averages of -1.5 and 1.5 and the like must round toward zero
    send_word(imuoc_pkg::CmdCalibrate, 1'b1,
              {16'h7fff, 16'h8000, 16'h0001, 16'hffff, 16'h0003, 16'hfffd});
    send_word(imuoc_pkg::CmdCalibrate, 1'b1,
              {16'h0000, 16'hffff, 16'h0000, 16'h0000, 16'h0000, 16'h0000});
    send_word(imuoc_pkg::CmdCompensate, 1'b1, all_axes(16'h0000));
  endtask

  task automatic test_zero_count();
    wait_drained();
    cfg_write(imuoc_pkg::RegCalCount, 16'd1);
    cfg_write(imuoc_pkg::RegGravity, 16'd100);
    send_word(imuoc_pkg::CmdCalibrate, 1'b1,
              {16'h0777, 16'hf123, 16'h0042, 16'h1000, 16'hfffe, 16'h8001});
    wait_drained();
    cfg_write(imuoc_pkg::RegCalCount, 16'd0);
    send_word(imuoc_pkg::CmdCalibrate, 1'b1, all_axes(16'h2222));
    send_word(imuoc_pkg::CmdCompensate, 1'b1, all_axes(16'h0000));
  endtask

  // Longer run with averages at both limits and a 17-bit z offset.
  task automatic test_longest_run();
    imu_axes_t a;
    wait_drained();
    cfg_write(imuoc_pkg::RegCalCount, 16'd48);
    cfg_write(imuoc_pkg::RegGravity, 16'h7fff);
    a = {16'h7fff, 16'h7fff, 16'h7fff, 16'h8000, 16'h8000, 16'h8000};
    send_word(imuoc_pkg::CmdCalibrate, 1'b1, a);
    while (left_cnt != 0) begin
      if ($urandom_range(9) == 0) send_word(imuoc_pkg::CmdCalibrate, 1'b0, pick_sample());
      else send_word(imuoc_pkg::CmdCalibrate, 1'b1, a);
    end
    send_word(imuoc_pkg::CmdCompensate, 1'b1, all_axes(16'h7fff));
    send_word(imuoc_pkg::CmdCompensate, 1'b1, all_axes(16'h8000));
  endtask

  task automatic test_random_traffic(input int words, input int src_pct, input int sink_pct);
    int unsigned start;
    int pick;
    int n;
    int i;
    wait_drained();
    src_idle_pct   = src_pct;
    sink_stall_pct = sink_pct;
    randomize_registers();
    start = words_sent;
    while (words_sent - start < words) begin
      pick = int'($urandom_range(99));
      if (pick < 6) begin
        wait_drained();
        randomize_registers();
      end else if (pick < 65) begin
        if (left_cnt != 0) n = int'(left_cnt);
        else if (cal_count_q == 0) n = 1;
        else n = int'(cal_count_q);
        // run may be left unfinished for now
        if ($urandom_range(9) == 0) n = int'($urandom_range(1, n));
        for (i = 0; i < n; i++) begin
          if ($urandom_range(9) == 0) begin
            send_word(imuoc_pkg::CmdCompensate, $urandom_range(9) != 0, pick_sample());
          end
          send_word(imuoc_pkg::CmdCalibrate, $urandom_range(99) < 88, pick_sample());
        end
      end else begin
        n = int'($urandom_range(1, 8));
        for (i = 0; i < n; i++) begin
          send_word(imuoc_pkg::CmdCompensate, $urandom_range(9) != 0, pick_sample());
        end
      end
    end
  endtask

  initial begin
    int i;
    rst_ni         = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_addr_i     = imuoc_pkg::RegCalCount;
    cfg_data_i     = '0;
    s_axis_tvalid  = 1'b0;
    s_axis_tdata   = '0;
    s_axis_tuser   = '0;
    m_axis_tready  = 1'b0;
    src_idle_pct   = 0;
    sink_stall_pct = 0;
    errors         = 0;
    words_sent     = 0;
    words_checked  = 0;
    runs_done      = 0;
    runs_failed    = 0;
    cycle_cnt      = 0;
    cal_count_q    = imuoc_pkg::CalCountReset;
    gravity_q      = imuoc_pkg::GravityReset;
    left_cnt       = 0;
    valid_cnt      = 0;
    for (i = 0; i < Axes; i++) begin
      axis_sum[i] = 0;
      axis_off[i] = 0;
    end

    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_compensate_at_reset();
    test_default_run();
    test_saturation();
    test_no_valid_sample();
    test_truncation();
    test_zero_count();
    test_longest_run();
    test_random_traffic(250, 0, 0);
    test_random_traffic(250, 75, 0);
    test_random_traffic(250, 0, 75);
    test_random_traffic(250, 27, 27);

    wait_drained();
    repeat (DrainCycles) @(posedge clk_i);
    if (imu_results_due.size() != 0) begin
      $error("%0d result words never arrived", imu_results_due.size());
      errors++;
    end

    $display("Sent %0d sample words, checked %0d result words; %0d runs averaged, %0d %s",
             words_sent, words_checked, runs_done, runs_failed, "refused or empty.");
    $display("Run lengths 0 to 800, gravity 0 to 32767, saturation both ways, four pacings.");
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ----- files.f -----
sv/imuoc_pkg.sv
sv/imuoc_div.sv
sv/imu_offset_calibrate_compensate.sv
tb/tb_imu_offset_calibrate_compensate.sv
